[hdl/vsh_pkg.sv]
// Shared constants, request codes and the histogram command word for the
// voxel store with value histogram. No dependencies.
package vsh_pkg;

  localparam int EDGE       = 32;
  localparam int CODE_BITS  = 6;
  localparam int POS_BITS   = $clog2(EDGE);
  localparam int CELL_BITS  = 3 * POS_BITS;
  localparam int CELL_TOTAL = EDGE * EDGE * EDGE;
  localparam int CODE_TOTAL = 2 ** CODE_BITS;
  localparam int COUNT_BITS = $clog2(CELL_TOTAL + 1);
  localparam int DIST_BITS  = $clog2(CODE_TOTAL + 1);

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic                 init_we;
    logic [CODE_BITS-1:0] init_idx;
    logic                 rd_new;
    logic [CODE_BITS-1:0] new_code;
    logic                 rd_old;
    logic [CODE_BITS-1:0] old_code;
    logic                 dec;
    logic                 inc;
  } hist_cmd_t;

endpackage

[hdl/vsh_hist.sv]
// Per-code cell counts in a two-read, one-write memory plus the distinct count.
// Depends on vsh_pkg.
module vsh_hist
  import vsh_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hist_cmd_t            cmd_i,
  output logic [DIST_BITS-1:0] distinct_o
);

  logic [COUNT_BITS-1:0] cnt_mem [CODE_TOTAL];
  logic [COUNT_BITS-1:0] old_cnt_q;
  logic [COUNT_BITS-1:0] new_cnt_q;
  logic [DIST_BITS-1:0]  distinct_q, distinct_d;

  logic                  we;
  logic [CODE_BITS-1:0]  waddr;
  logic [COUNT_BITS-1:0] wdata;

  always_comb begin
    we    = 1'b0;
    waddr = cmd_i.init_idx;
    wdata = '0;
    if (cmd_i.init_we) begin
      we    = 1'b1;
      waddr = cmd_i.init_idx;
      wdata = (cmd_i.init_idx == '0) ? COUNT_BITS'(CELL_TOTAL) : '0;
    end else if (cmd_i.dec) begin
      we    = 1'b1;
      waddr = cmd_i.old_code;
      wdata = old_cnt_q - COUNT_BITS'(1);
    end else if (cmd_i.inc) begin
      we    = 1'b1;
      waddr = cmd_i.new_code;
      wdata = new_cnt_q + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      cnt_mem[waddr] <= wdata;
    end
    if (cmd_i.rd_old) begin
      old_cnt_q <= cnt_mem[cmd_i.old_code];
    end
    if (cmd_i.rd_new) begin
      new_cnt_q <= cnt_mem[cmd_i.new_code];
    end
  end

  // Drop on the last cell of the old code, add on the first cell of the new one.
  always_comb begin
    distinct_d = distinct_q;
    if (cmd_i.dec && old_cnt_q == COUNT_BITS'(1)) begin
      distinct_d = distinct_q - DIST_BITS'(1);
    end else if (cmd_i.inc && new_cnt_q == '0) begin
      distinct_d = distinct_q + DIST_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      distinct_q <= DIST_BITS'(1);
    end else begin
      distinct_q <= distinct_d;
    end
  end

  assign distinct_o = distinct_q;

endmodule

[hdl/voxel_store_with_value_histogram_core.sv]
// Voxel cube of material codes with a per-code histogram and distinct count.
// Sequence: a read, a clear or a write of the same code gives its strobe from
// ST_OLD; a write that changes a cell goes on through ST_DEC and ST_INC first.
// One word at a time: busy stays high through the cell read and, for a change,
// the two count write-backs through the single write port of the count memory.
// Reset: a clearing pass over all 32768 cells zeroes the cube (busy stays high).
// Depends on vsh_pkg and vsh_hist.
module voxel_store_with_value_histogram_core
  import vsh_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           kind_i,
  input  logic [4:0]           pos_x_i,
  input  logic [4:0]           pos_y_i,
  input  logic [4:0]           pos_z_i,
  input  logic [5:0]           new_code_i,
  output logic                 res_valid_o,
  output logic [5:0]           read_code_o,
  output logic                 is_uniform_o,
  output logic [6:0]           distinct_codes_o,
  output logic                 changed_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OLD,
    ST_DEC,
    ST_INC
  } state_e;

  state_e state_q;

  // Clearing pass address.
  logic [CELL_BITS-1:0] clr_idx_q;

  // Captured request word (payload, no reset).
  logic [1:0]           kind_q;
  logic [CELL_BITS-1:0] idx_q;
  logic [CODE_BITS-1:0] code_q;
  logic [CODE_BITS-1:0] old_q;

  logic                 changed_q;
  logic                 res_valid_q;
  logic [CODE_BITS-1:0] read_code_q;

  logic                 accept;
  logic [CELL_BITS-1:0] req_idx;
  logic [CODE_BITS-1:0] req_code;

  // Cell memory: one write and one read port, read data registered.
  logic [CODE_BITS-1:0] cell_mem [CELL_TOTAL];
  logic [CODE_BITS-1:0] cell_rd_q;
  logic                 cell_we;
  logic [CELL_BITS-1:0] cell_waddr;
  logic [CODE_BITS-1:0] cell_wdata;

  hist_cmd_t            hcmd;
  logic [DIST_BITS-1:0] distinct;

  assign accept   = start && !busy;
  // Index is x-major: (x*EDGE + y)*EDGE + z.
  assign req_idx  = {pos_x_i[POS_BITS-1:0], pos_y_i[POS_BITS-1:0], pos_z_i[POS_BITS-1:0]};
  assign req_code = new_code_i[CODE_BITS-1:0];

  // A write that changes the cell: the old code is the registered cell read.
  logic write_change;
  assign write_change = (state_q == ST_OLD) && (kind_q == KIND_WRITE) && (cell_rd_q != code_q);

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = idx_q;
    cell_wdata = code_q;
    if (state_q == ST_CLEAR) begin
      cell_we    = 1'b1;
      cell_waddr = clr_idx_q;
      cell_wdata = '0;
    end else if (write_change) begin
      cell_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (accept) begin
      cell_rd_q <= cell_mem[req_idx];
    end
  end

  // Histogram commands: the new code's count is fetched at accept, the old
  // code's count once the cell read returns; write back old, then new.
  always_comb begin
    hcmd          = '0;
    hcmd.init_we  = (state_q == ST_CLEAR) && (clr_idx_q < CELL_BITS'(CODE_TOTAL));
    hcmd.init_idx = clr_idx_q[CODE_BITS-1:0];
    hcmd.rd_new   = accept;
    hcmd.new_code = (state_q == ST_IDLE) ? req_code : code_q;
    hcmd.rd_old   = write_change;
    hcmd.old_code = (state_q == ST_OLD) ? cell_rd_q : old_q;
    hcmd.dec      = (state_q == ST_DEC);
    hcmd.inc      = (state_q == ST_INC);
  end

  vsh_hist u_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (hcmd),
    .distinct_o (distinct)
  );

  // Payload capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      idx_q  <= req_idx;
      code_q <= req_code;
    end
    if (write_change) begin
      old_q <= cell_rd_q;
    end
    if (state_q == ST_OLD) begin
      read_code_q <= (kind_q == KIND_WRITE) ? code_q : cell_rd_q;
    end
  end

  // Sequencer with the strobe and flag registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      changed_q   <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_idx_q <= clr_idx_q + CELL_BITS'(1);
          if (clr_idx_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_OLD;
          end
        end
        ST_OLD: begin
          // Any write sets the flag, a clear drops it, other kinds leave it.
          if (kind_q == KIND_WRITE) begin
            changed_q <= 1'b1;
          end else if (kind_q == KIND_CLEAR) begin
            changed_q <= 1'b0;
          end
          if (write_change) begin
            state_q <= ST_DEC;
          end else begin
            res_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_DEC: begin
          state_q <= ST_INC;
        end
        ST_INC: begin
          res_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy             = (state_q != ST_IDLE);
  assign res_valid_o      = res_valid_q;
  assign read_code_o      = 6'(read_code_q);
  assign changed_o        = changed_q;
  assign distinct_codes_o = 7'(distinct);
  assign is_uniform_o     = (distinct == DIST_BITS'(1));

endmodule

[hdl/vsh_checker.sv]
// Port-level checks for the voxel store core, attached by bind.
// Depends on vsh_pkg.
module vsh_checker
  import vsh_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] kind_i,
  input logic       res_valid_o,
  input logic       is_uniform_o,
  input logic [6:0] distinct_codes_o,
  input logic       changed_o
);

  // An accepted word holds the core busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("core not busy after accepting a word");

  // The result strobe ends the work on a word.
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result strobe while still busy");

  // One result per word, never in back-to-back cycles.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe repeated");

  // Uniform exactly when one code is present, and the count stays in range.
  a_uniform_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (is_uniform_o == (distinct_codes_o == 7'd1)) &&
                    distinct_codes_o != 7'd0 && distinct_codes_o <= 7'(CODE_TOTAL))
    else $error("distinct count out of range or uniform flag mismatch");

  // A write word that keeps its cell's code reports the changed flag set.
  a_write_sets_changed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && kind_i == KIND_WRITE |=> ##1 (res_valid_o ? changed_o : 1'b1))
    else $error("write did not set the changed flag");

endmodule

bind voxel_store_with_value_histogram_core vsh_checker u_vsh_checker (.*);

[sim/voxel_store_with_value_histogram_core_tb.sv]
// Testbench for voxel_store_with_value_histogram_core: directed and random
// voxel requests checked against a cycle-free model of the cube and histogram.
// Depends on vsh_pkg and the core RTL.
`timescale 1ns / 1ps

module voxel_store_with_value_histogram_core_tb;
  import vsh_pkg::*;

  // Kind 3 has no package name; the core treats it as a plain read.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // The run is the clearing pass after reset, which writes every cell, then
  // about 1800 words, each through the core's sequencer states plus random
  // sender gaps. Allow several times the whole run.
  localparam int CYCLE_LIMIT = 400000;
  localparam int WORD_TARGET = 1700;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] x;
    logic [4:0] y;
    logic [4:0] z;
    logic [5:0] code;
  } voxel_req_t;

  typedef struct packed {
    logic [5:0] code;
    logic       uniform;
    logic [6:0] distinct;
    logic       changed;
  } voxel_rsp_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] kind_i = KIND_READ;
  logic [4:0] pos_x_i = '0;
  logic [4:0] pos_y_i = '0;
  logic [4:0] pos_z_i = '0;
  logic [5:0] new_code_i = '0;
  logic       res_valid_o;
  logic [5:0] read_code_o;
  logic       is_uniform_o;
  logic [6:0] distinct_codes_o;
  logic       changed_o;

  voxel_store_with_value_histogram_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .pos_z_i          (pos_z_i),
    .new_code_i       (new_code_i),
    .res_valid_o      (res_valid_o),
    .read_code_o      (read_code_o),
    .is_uniform_o     (is_uniform_o),
    .distinct_codes_o (distinct_codes_o),
    .changed_o        (changed_o)
  );

  // Shadow copy of the cube, the per-code histogram and the flags.
  logic [5:0]  shadow_cells [CELL_TOTAL];
  int unsigned code_tally [CODE_TOTAL];
  int unsigned codes_present;
  logic        changed_shadow;

  voxel_req_t  pending_words [$];
  voxel_rsp_t  expected_results [$];
  int unsigned words_queued = 0;
  int unsigned words_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Apply one accepted word to the shadow state and return what the core
  // must report for it.
  function automatic voxel_rsp_t apply_request(input voxel_req_t req);
    int unsigned idx;
    logic [5:0]  prior;
    voxel_rsp_t  rsp;
    // x is the slowest index, z the fastest: the z term is never scaled.
    idx = 32'({req.x, req.y, req.z});
    if (req.kind == KIND_WRITE) begin
      prior = shadow_cells[idx];
      if (prior != req.code) begin
        shadow_cells[idx] = req.code;
        if (code_tally[prior] > 0) begin
          code_tally[prior]--;
          if (code_tally[prior] == 0 && codes_present > 0) codes_present--;
        end
        if (code_tally[req.code] == 0) codes_present++;
        code_tally[req.code]++;
      end
      // Any write sets the flag, even one that stores the same code.
      changed_shadow = 1'b1;
    end else if (req.kind == KIND_CLEAR) begin
      changed_shadow = 1'b0;
    end
    rsp.code     = shadow_cells[idx];
    rsp.uniform  = (codes_present == 1);
    rsp.distinct = 7'(codes_present);
    rsp.changed  = changed_shadow;
    return rsp;
  endfunction

  task automatic queue_word(input logic [1:0] k, input logic [4:0] x, input logic [4:0] y,
                            input logic [4:0] z, input logic [5:0] c);
    voxel_req_t req;
    req.kind = k;
    req.x    = x;
    req.y    = y;
    req.z    = z;
    req.code = c;
    pending_words.push_back(req);
    words_queued++;
  endtask

  // Same as queue_word, with the position given as a packed {x, y, z} address.
  task automatic queue_cell(input logic [1:0] k, input logic [14:0] addr,
                            input logic [5:0] c);
    queue_word(k, addr[14:10], addr[9:5], addr[4:0], c);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hold reset low from time zero, then release it for the rest of the run.
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Driver: a word is taken at the edge where start is high and busy low.
  // Keep start high while busy; otherwise either drop start or present
  // the next pending word. Idling is switched off over a long middle stretch.
  always @(posedge clk_i) begin
    voxel_req_t nxt;
    voxel_req_t taken;
    logic       fire;
    logic       calm;
    if (rst_ni) begin
      fire = start && !busy;
      if (fire) begin
        taken.kind = kind_i;
        taken.x    = pos_x_i;
        taken.y    = pos_y_i;
        taken.z    = pos_z_i;
        taken.code = new_code_i;
        expected_results.push_back(apply_request(taken));
        words_accepted++;
      end
      calm = (words_accepted >= 700 && words_accepted < 1100);
      if (start && !fire) begin
        // hold the current word until the core takes it
      end else if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
        nxt = pending_words.pop_front();
        kind_i     <= nxt.kind;
        pos_x_i    <= nxt.x;
        pos_y_i    <= nxt.y;
        pos_z_i    <= nxt.z;
        new_code_i <= nxt.code;
        start      <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobe must match the oldest expected result.
  always @(posedge clk_i) begin
    voxel_rsp_t want;
    if (rst_ni && res_valid_o) begin
      if (expected_results.size() == 0) begin
        $error("result word with no request outstanding");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (read_code_o !== want.code) begin
          $error("read_code: expected %0d, got %0d", want.code, read_code_o);
          mismatches++;
        end
        if (is_uniform_o !== want.uniform) begin
          $error("is_uniform: expected %0d, got %0d", want.uniform, is_uniform_o);
          mismatches++;
        end
        if (distinct_codes_o !== want.distinct) begin
          $error("distinct_codes: expected %0d, got %0d", want.distinct, distinct_codes_o);
          mismatches++;
        end
        if (changed_o !== want.changed) begin
          $error("changed: expected %0d, got %0d", want.changed, changed_o);
          mismatches++;
        end
      end
    end
  end

  // Build the stimulus, then wait for the core to drain and report.
  initial begin
    bit          touched [int unsigned];
    logic [14:0] hot [8];
    logic [14:0] base;
    logic [5:0]  order [64];
    logic [5:0]  swap;
    int unsigned pick;
    int unsigned roll;
    int unsigned span;

    // Reset state: every cell holds code 0, so code 0 counts the whole cube.
    for (int i = 0; i < CELL_TOTAL; i++) shadow_cells[i] = '0;
    for (int i = 0; i < CODE_TOTAL; i++) code_tally[i] = 0;
    code_tally[0]  = CELL_TOTAL;
    codes_present  = 1;
    changed_shadow = 1'b1;

    // Directed part: corners, every kind, same-code writes, a count falling
    // back to zero, and positions with swapped x and z.
    queue_word(KIND_READ,  5'd0,  5'd0,  5'd0,  6'd0);
    queue_word(KIND_SPARE, 5'd31, 5'd31, 5'd31, 6'd63);
    queue_word(KIND_CLEAR, 5'd0,  5'd0,  5'd0,  6'd0);
    queue_word(KIND_READ,  5'd31, 5'd0,  5'd17, 6'd63);
    queue_word(KIND_WRITE, 5'd0,  5'd0,  5'd0,  6'd0);
    queue_word(KIND_CLEAR, 5'd31, 5'd31, 5'd31, 6'd63);
    queue_word(KIND_WRITE, 5'd31, 5'd31, 5'd31, 6'd63);
    queue_word(KIND_WRITE, 5'd1,  5'd2,  5'd3,  6'd5);
    queue_word(KIND_READ,  5'd1,  5'd2,  5'd3,  6'd0);
    queue_word(KIND_READ,  5'd3,  5'd2,  5'd1,  6'd0);
    queue_word(KIND_WRITE, 5'd1,  5'd2,  5'd3,  6'd63);
    queue_word(KIND_CLEAR, 5'd1,  5'd2,  5'd3,  6'd0);
    queue_word(KIND_WRITE, 5'd1,  5'd2,  5'd3,  6'd63);
    queue_word(KIND_WRITE, 5'd31, 5'd31, 5'd31, 6'd0);
    queue_word(KIND_WRITE, 5'd1,  5'd2,  5'd3,  6'd0);
    queue_word(KIND_WRITE, 5'd21, 5'd10, 5'd31, 6'd42);
    queue_word(KIND_WRITE, 5'd10, 5'd21, 5'd0,  6'd21);
    queue_word(KIND_SPARE, 5'd21, 5'd10, 5'd31, 6'd0);
    queue_word(KIND_WRITE, 5'd21, 5'd10, 5'd31, 6'd0);
    queue_word(KIND_WRITE, 5'd10, 5'd21, 5'd0,  6'd0);
    queue_word(KIND_CLEAR, 5'd0,  5'd31, 5'd0,  6'd0);

    // Random part in episodes. Each episode dirties some cells and then
    // writes them all back to code 0, so the cube returns to uniform and the
    // distinct count keeps sweeping between 1 and high values.
    while (words_queued < WORD_TARGET) begin
      if ($urandom_range(3) == 0) begin
        // Sweep: all 64 codes into 64 distinct cells in shuffled order.
        for (int i = 0; i < 64; i++) order[i] = 6'(i);
        for (int i = 63; i > 0; i--) begin
          pick = $urandom_range(i);
          swap = order[i];
          order[i] = order[pick];
          order[pick] = swap;
        end
        base = 15'($urandom);
        for (int i = 0; i < 64; i++) begin
          queue_cell(KIND_WRITE, base + 15'(i), order[i]);
          touched[base + 15'(i)] = 1'b1;
          if ($urandom_range(9) == 0) queue_cell(KIND_READ, base + 15'(i), 6'($urandom));
        end
      end else begin
        // Hotspot: a few cells rewritten over and over, mostly from a small
        // code set so that counts drop to zero and come back.
        for (int i = 0; i < 8; i++) hot[i] = 15'($urandom);
        span = $urandom_range(40, 120);
        for (int n = 0; n < span; n++) begin
          roll = $urandom_range(99);
          pick = $urandom_range(7);
          if (roll < 45) begin
            queue_cell(KIND_WRITE, hot[pick],
                       ($urandom_range(1) == 0) ? 6'($urandom_range(3)) : 6'($urandom));
            touched[hot[pick]] = 1'b1;
          end else if (roll < 75) begin
            queue_cell(KIND_READ, hot[pick], 6'($urandom));
          end else if (roll < 82) begin
            base = 15'($urandom);
            queue_cell(KIND_WRITE, base, 6'($urandom));
            touched[base] = 1'b1;
          end else if (roll < 90) begin
            queue_cell(KIND_READ, 15'($urandom), 6'($urandom));
          end else if (roll < 95) begin
            queue_cell(KIND_CLEAR, 15'($urandom), 6'($urandom));
          end else begin
            queue_cell(KIND_SPARE, hot[pick], 6'($urandom));
          end
        end
      end
      // Restore every dirtied cell to code 0.
      foreach (touched[a]) queue_cell(KIND_WRITE, 15'(a), 6'd0);
      touched.delete();
      if ($urandom_range(1) == 0) queue_cell(KIND_CLEAR, 15'($urandom), 6'($urandom));
    end

    // Drain: all words taken, all results seen, then a few quiet cycles.
    @(posedge rst_ni);
    do @(negedge clk_i);
    while (words_accepted < words_queued || expected_results.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/vsh_pkg.sv
hdl/vsh_hist.sv
hdl/voxel_store_with_value_histogram_core.sv
hdl/vsh_checker.sv
sim/voxel_store_with_value_histogram_core_tb.sv
